[rtl/gdc_pkg.sv]
// ----------------------------------------------------------------------------
// gdc_pkg: shared types, codes and calendar functions for the date counter
// Holds the operation codes, the date and flag structs, the stream packing
// widths and the leap-year and month-length helpers.
// ----------------------------------------------------------------------------
package gdc_pkg;

   // Field widths
   localparam int OP_W    = 2;
   localparam int GDAY_W  = 6;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int TDATA_W = 32;

   // Default last year that may be held
   localparam int MAX_YEAR_DEFAULT = 9999;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_INC     = 2'd1;
   localparam logic [OP_W-1:0] OP_DEC     = 2'd2;
   localparam logic [OP_W-1:0] OP_COMPARE = 2'd3;

   // Date loaded after reset or after an invalid load
   localparam logic [DAY_W-1:0]   DEFAULT_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0] DEFAULT_MONTH = 4'd1;
   localparam logic [YEAR_W-1:0]  DEFAULT_YEAR  = 14'd2023;

   localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
   localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;

   // Reciprocal of 25 scaled by 2^17, exact enough for any 14-bit year
   localparam int            RECIP25_SHIFT = 17;
   localparam logic [12:0]   RECIP25       = 13'd5243;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [GDAY_W-1:0]  day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } request_type;

   typedef struct packed {
      logic at_limit;
      logic dates_equal;
      logic load_accepted;
   } flags_type;

   // Leap year: divisible by 4 and not by 100, or divisible by 400.
   // y % 100 == 0 <=> 4 | y and 25 | y ; y % 400 == 0 <=> 16 | y and 25 | y.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W+12:0] prod;
      logic [9:0]         quot;
      logic [14:0]        back;
      logic               div4;
      logic               div16;
      logic               div25;
      prod  = {13'd0, year} * {{YEAR_W{1'b0}}, RECIP25};
      quot  = prod[RECIP25_SHIFT +: 10];
      back  = {1'b0, quot, 4'd0} + {2'd0, quot, 3'd0} + {5'd0, quot};
      div25 = (back == {1'b0, year});
      div4  = (year[1:0] == 2'd0);
      div16 = (year[3:0] == 4'd0);
      return div4 && (!div25 || div16);
   endfunction

   // Days in a month; zero for a month outside 1..12
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic               leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd2:                                 len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:              len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
         4'd12:                                len = 5'd31;
         default:                              len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

[rtl/gregorian_date_counter_unit.sv]
// ----------------------------------------------------------------------------
// gregorian_date_counter_unit: Gregorian calendar date counter
// Holds one date and applies load, step forward, step back or compare.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle, sustained while rsp_tready is
// high; a held response stalls it. It returns exactly one response per
// request: a request passes through the request register, then the
// date-update stage that writes the stored date and the response register
// together. The stored date feeds back into that one stage, so consecutive
// requests see each other's updates with no gap. A load with an invalid
// date stores 1/1/2023; steps at 31/12/MAX_YEAR or 1/1/0 hold the date and
// raise at_limit. After reset the stored date is 1/1/2023.
module gregorian_date_counter_unit
   import gdc_pkg::*;
#(
   parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // [1:0] operation, [7:2] given_day, [11:8] given_month,
   // [25:12] given_year, [31:26] zero
   input  logic [TDATA_W-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [4:0] current_day, [8:5] current_month, [22:9] current_year,
   // [23] load_accepted, [24] dates_equal, [25] at_limit, [31:26] zero
   output logic [TDATA_W-1:0] rsp_tdata
);

   localparam int RSP_W = $bits(flags_type) + $bits(date_type);

   request_type req_in;
   request_type req_ff;
   logic        req_valid_ff;
   logic        req_valid_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   date_type    date_ff;
   date_type    date_in;
   flags_type   flags_in;
   logic [TDATA_W-1:0] rsp_data_ff;
   logic        accept;
   logic        advance;

   // Unpack request, first field in the low bits
   assign req_in.op    = req_tdata[1:0];
   assign req_in.day   = req_tdata[7:2];
   assign req_in.month = req_tdata[11:8];
   assign req_in.year  = req_tdata[25:12];

   // Handshake
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Date update
   gdc_step #(
      .MAX_YEAR(MAX_YEAR)
   ) u_step (
      .req   (req_ff),
      .cur   (date_ff),
      .nxt   (date_in),
      .flags (flags_in)
   );

   // Control and stored date
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         date_ff.day   <= DEFAULT_DAY;
         date_ff.month <= DEFAULT_MONTH;
         date_ff.year  <= DEFAULT_YEAR;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            date_ff <= date_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_data_ff <= {{(TDATA_W-RSP_W){1'b0}}, flags_in,
                         date_in.year, date_in.month, date_in.day};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Assertions
   localparam logic [YEAR_W-1:0] MaxYearChk = YEAR_W'(MAX_YEAR);

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (date_ff.month >= 4'd1) && (date_ff.month <= LAST_MONTH))
      else $error("stored month out of range");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      (date_ff.day >= 5'd1) &&
      (date_ff.day <= month_length(date_ff.month, is_leap(date_ff.year))))
      else $error("stored day past month end");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (date_ff.year <= MaxYearChk) || (date_ff.year == DEFAULT_YEAR))
      else $error("stored year above bound");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tdata[RSP_W-1 -: $bits(flags_type)]) <= 1)
      else $error("more than one response flag set");

   a_date_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(date_ff))
      else $error("stored date changed without a request");

endmodule

[rtl/gdc_step.sv]
// ----------------------------------------------------------------------------
// gdc_step: next-date logic for one request
// From the stored date and one request, forms the date held afterwards and
// the three result flags. Pure combinational logic.
// ----------------------------------------------------------------------------
module gdc_step
   import gdc_pkg::*;
#(
   parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
   input  request_type req,
   input  date_type    cur,
   output date_type    nxt,
   output flags_type   flags
);

   localparam logic [YEAR_W-1:0] MaxYearW = YEAR_W'(MAX_YEAR);

   logic               cur_leap;
   logic               given_leap;
   logic [DAY_W-1:0]   cur_len;
   logic [DAY_W-1:0]   prev_len;
   logic [DAY_W-1:0]   given_len;
   logic [MONTH_W-1:0] prev_month;
   logic               load_ok;

   // Month lengths for the stored date and for the given date
   assign cur_leap   = is_leap(cur.year);
   assign given_leap = is_leap(req.year);
   assign prev_month = cur.month - 4'd1;
   assign cur_len    = month_length(cur.month, cur_leap);
   assign prev_len   = month_length(prev_month, cur_leap);
   assign given_len  = month_length(req.month, given_leap);

   // Load check; an out-of-range month has zero length and fails the day test
   assign load_ok = (req.year <= MaxYearW) &&
                    (req.day != '0) &&
                    (req.day <= {1'b0, given_len});

   always_comb begin
      nxt   = cur;
      flags = '0;
      case (req.op)
         OP_LOAD: begin
            if (load_ok) begin
               nxt.day             = req.day[DAY_W-1:0];
               nxt.month           = req.month;
               nxt.year            = req.year;
               flags.load_accepted = 1'b1;
            end else begin
               nxt.day   = DEFAULT_DAY;
               nxt.month = DEFAULT_MONTH;
               nxt.year  = DEFAULT_YEAR;
            end
         end
         OP_INC: begin
            if (cur.day < cur_len) begin
               nxt.day = cur.day + 5'd1;
            end else if (cur.month < LAST_MONTH) begin
               nxt.day   = 5'd1;
               nxt.month = cur.month + 4'd1;
            end else if (cur.year < MaxYearW) begin
               nxt.day   = 5'd1;
               nxt.month = 4'd1;
               nxt.year  = cur.year + 14'd1;
            end else begin
               flags.at_limit = 1'b1;
            end
         end
         OP_DEC: begin
            if (cur.day > 5'd1) begin
               nxt.day = cur.day - 5'd1;
            end else if (cur.month > 4'd1) begin
               nxt.month = prev_month;
               nxt.day   = prev_len;
            end else if (cur.year != '0) begin
               nxt.year  = cur.year - 14'd1;
               nxt.month = LAST_MONTH;
               nxt.day   = LAST_DAY;
            end else begin
               flags.at_limit = 1'b1;
            end
         end
         default: begin
            // Compare: raw given fields against the stored date
            flags.dates_equal = (req.day == {1'b0, cur.day}) &&
                                (req.month == cur.month) &&
                                (req.year == cur.year);
         end
      endcase
   end

endmodule
